FILE: src/olist_pkg.sv
// Shared types and constants for the ordered list engine.
package olist_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int POS_W    = 7;
    localparam int OP_W     = 4;
    localparam int ST_W     = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_REAR  = 4'd1,
        OP_INS_POS   = 4'd2,
        OP_DEL_FRONT = 4'd3,
        OP_DEL_REAR  = 4'd4,
        OP_DEL_POS   = 4'd5,
        OP_DEL_KEY   = 4'd6,
        OP_SEARCH    = 4'd7,
        OP_DISPLAY   = 4'd8
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UP,
        S_INS_WR,
        S_DEL_VAL,
        S_DN,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  value;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   length;
        logic               last;
    } t_result;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
    } t_mem_wr;

endpackage

FILE: src/olist_store.sv
// Element storage: one write port, one registered read port.
module olist_store (
    input  logic                          i_clk,
    input  olist_pkg::t_mem_wr            i_wr,
    input  logic [olist_pkg::ADDR_W-1:0]  i_rd_addr,
    output logic [olist_pkg::DATA_W-1:0]  o_rd_data
);
    import olist_pkg::*;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/olist_ctrl.sv
// Sequencer: decodes an operation, walks an element per cycle unless stalled.
module olist_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  olist_pkg::t_opcode            i_op,
    input  logic [olist_pkg::DATA_W-1:0]  i_key,
    input  logic [olist_pkg::POS_W-1:0]   i_pos,
    output olist_pkg::t_mem_wr            o_wr,
    output logic [olist_pkg::ADDR_W-1:0]  o_rd_addr,
    input  logic [olist_pkg::DATA_W-1:0]  i_rd_data,
    input  logic                          i_slot_free,
    output logic                          o_emit,
    output olist_pkg::t_result            o_res
);
    import olist_pkg::*;

    localparam int XW = CNT_W + 1;
    localparam int PW = POS_W + 1;

    t_state             r_state,  n_state;
    t_opcode            r_op,     n_op;
    logic [DATA_W-1:0]  r_key,    n_key;
    logic [POS_W-1:0]   r_pos,    n_pos;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic [ADDR_W-1:0]  r_ptr,    n_ptr;
    logic [ADDR_W-1:0]  r_tgt,    n_tgt;
    t_status            r_status, n_status;
    logic [DATA_W-1:0]  r_res,    n_res;
    logic [POS_W-1:0]   r_rpos,   n_rpos;

    logic [XW-1:0]      ptr_x;
    logic [XW-1:0]      cnt_x;
    logic [PW-1:0]      pos_p;
    logic [PW-1:0]      cnt_p;
    logic [CNT_W-1:0]   ins_tgt;
    logic [CNT_W-1:0]   del_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_pos    <= n_pos;
        r_ptr    <= n_ptr;
        r_tgt    <= n_tgt;
        r_status <= n_status;
        r_res    <= n_res;
        r_rpos   <= n_rpos;
    end

    always_comb begin
        ptr_x = XW'(r_ptr);
        cnt_x = XW'(r_count);
        pos_p = PW'(r_pos);
        cnt_p = PW'(r_count);

        case (r_op)
            OP_INS_FRONT: ins_tgt = '0;
            OP_INS_REAR:  ins_tgt = r_count;
            default:      ins_tgt = CNT_W'(r_pos - POS_W'(1));
        endcase
        case (r_op)
            OP_DEL_FRONT: del_idx = '0;
            OP_DEL_REAR:  del_idx = r_count - CNT_W'(1);
            default:      del_idx = CNT_W'(r_pos - POS_W'(1));
        endcase

        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_pos    = r_pos;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_tgt    = r_tgt;
        n_status = r_status;
        n_res    = r_res;
        n_rpos   = r_rpos;

        o_ready   = 1'b0;
        o_wr      = '0;
        o_rd_addr = r_ptr;
        o_emit    = 1'b0;
        o_res     = '0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_op    = i_op;
                    n_key   = i_key;
                    n_pos   = i_pos;
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_status = ST_OK;
                n_res    = '0;
                n_rpos   = '0;
                case (r_op)
                    OP_INS_FRONT, OP_INS_REAR, OP_INS_POS: begin
                        if (cnt_x >= XW'(CAPACITY)) begin
                            n_status = ST_FULL;
                            n_state  = S_EMIT;
                        end else if (r_op == OP_INS_POS &&
                                     (r_pos == '0 || pos_p > cnt_p + PW'(1))) begin
                            n_status = ST_BADPOS;
                            n_state  = S_EMIT;
                        end else if (ins_tgt == r_count) begin
                            // append: nothing to move
                            o_wr.en   = 1'b1;
                            o_wr.addr = ADDR_W'(ins_tgt);
                            o_wr.data = r_key;
                            n_count   = r_count + CNT_W'(1);
                            n_state   = S_EMIT;
                        end else begin
                            o_rd_addr = ADDR_W'(r_count - CNT_W'(1));
                            n_ptr     = ADDR_W'(r_count - CNT_W'(1));
                            n_tgt     = ADDR_W'(ins_tgt);
                            n_state   = S_UP;
                        end
                    end
                    OP_DEL_FRONT, OP_DEL_REAR, OP_DEL_POS: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_EMIT;
                        end else if (r_op == OP_DEL_POS &&
                                     (r_pos == '0 || pos_p > cnt_p)) begin
                            n_status = ST_BADPOS;
                            n_state  = S_EMIT;
                        end else begin
                            o_rd_addr = ADDR_W'(del_idx);
                            n_ptr     = ADDR_W'(del_idx);
                            n_state   = S_DEL_VAL;
                        end
                    end
                    OP_DEL_KEY, OP_SEARCH, OP_DISPLAY: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_EMIT;
                        end else begin
                            o_rd_addr = '0;
                            n_ptr     = '0;
                            n_state   = S_SCAN;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end

            // move store[ptr] up by one, walking toward the insert point
            S_UP: begin
                o_wr.en   = 1'b1;
                o_wr.addr = ADDR_W'(ptr_x + XW'(1));
                o_wr.data = i_rd_data;
                if (r_ptr == r_tgt) begin
                    n_state = S_INS_WR;
                end else begin
                    o_rd_addr = r_ptr - ADDR_W'(1);
                    n_ptr     = r_ptr - ADDR_W'(1);
                end
            end

            S_INS_WR: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_tgt;
                o_wr.data = r_key;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_EMIT;
            end

            // read data holds the element being removed
            S_DEL_VAL: begin
                n_res  = i_rd_data;
                n_rpos = POS_W'(ptr_x + XW'(1));
                if (ptr_x + XW'(1) < cnt_x) begin
                    o_rd_addr = ADDR_W'(ptr_x + XW'(1));
                    n_state   = S_DN;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_EMIT;
                end
            end

            // close the gap: store[ptr] <= store[ptr+1]
            S_DN: begin
                o_wr.en   = 1'b1;
                o_wr.addr = r_ptr;
                o_wr.data = i_rd_data;
                if (ptr_x + XW'(2) < cnt_x) begin
                    o_rd_addr = ADDR_W'(ptr_x + XW'(2));
                    n_ptr     = ADDR_W'(ptr_x + XW'(1));
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_EMIT;
                end
            end

            S_SCAN: begin
                if (r_op == OP_DISPLAY) begin
                    if (i_slot_free) begin
                        o_emit         = 1'b1;
                        o_res.status   = ST_OK;
                        o_res.value    = i_rd_data;
                        o_res.position = POS_W'(ptr_x + XW'(1));
                        o_res.length   = POS_W'(r_count);
                        o_res.last     = (ptr_x + XW'(1) == cnt_x);
                        o_rd_addr      = ADDR_W'(ptr_x + XW'(1));
                        n_ptr          = ADDR_W'(ptr_x + XW'(1));
                        if (ptr_x + XW'(1) == cnt_x) begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (i_rd_data == r_key) begin
                    n_res    = i_rd_data;
                    n_rpos   = POS_W'(ptr_x + XW'(1));
                    n_status = ST_OK;
                    if (r_op == OP_SEARCH) begin
                        n_state = S_EMIT;
                    end else if (ptr_x + XW'(1) < cnt_x) begin
                        o_rd_addr = ADDR_W'(ptr_x + XW'(1));
                        n_state   = S_DN;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_EMIT;
                    end
                end else if (ptr_x + XW'(1) == cnt_x) begin
                    n_status = ST_NOTFOUND;
                    n_res    = '0;
                    n_rpos   = '0;
                    n_state  = S_EMIT;
                end else begin
                    o_rd_addr = ADDR_W'(ptr_x + XW'(1));
                    n_ptr     = ADDR_W'(ptr_x + XW'(1));
                end
            end

            S_EMIT: begin
                if (i_slot_free) begin
                    o_emit         = 1'b1;
                    o_res.status   = r_status;
                    o_res.value    = r_res;
                    o_res.position = r_rpos;
                    o_res.length   = POS_W'(r_count);
                    o_res.last     = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(CAPACITY))
        else $error("element count above capacity");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_slot_free)
        else $error("result emitted into a busy output slot");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
        (r_count == $past(r_count) + CNT_W'(1) || r_count + CNT_W'(1) == $past(r_count)))
        else $error("element count moved by more than one");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !o_wr.en)
        else $error("store written while idle");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

endmodule

FILE: src/ordered_list_engine.sv
// Ordered list engine: top level with stream ports and the output register.
//
// Slave channel carries one operation per item: tuser holds the opcode,
// tdata the value or key and the 1-based position. Master channel returns
// results: tuser holds the status, tdata the value, position and length,
// tlast marks the final result of an operation.
// One operation is worked at a time; s_axis_tready is high only while the
// sequencer waits for an item. An insert at an index first moves the
// elements from the last one down to that index up by one, a delete
// closes the gap behind the removed element, search and delete by key
// scan from the front, and display returns one result per element.
// The single read port of the element store is walked one element per
// cycle, except that a display walk can pause, as described below.
// The result sits in an output register, so the next operation is taken
// while it waits. When the receiver stalls, a display walk pauses on the
// current element and any other result waits in its state until the
// register frees. Reset empties the list; store contents stay undefined
// and are never read before being written.
module ordered_list_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [31:0] data_value, [38:32] list_position, [39] zero
    input  logic [olist_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // [3:0] opcode
    input  logic [olist_pkg::OP_W-1:0]          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [31:0] result_value, [38:32] found_position, [45:39] length_after, [47:46] zero
    output logic [olist_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // [2:0] status
    output logic [olist_pkg::ST_W-1:0]          o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);
    import olist_pkg::*;

    t_mem_wr            mem_wr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [DATA_W-1:0]  rd_data;
    logic               slot_free;
    logic               emit;
    t_result            res;

    logic               r_m_valid;
    t_result            r_m_res;

    assign slot_free = !r_m_valid || i_m_axis_tready;

    olist_store u_store (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    olist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (t_opcode'(i_s_axis_tuser)),
        .i_key       (i_s_axis_tdata[DATA_W-1:0]),
        .i_pos       (i_s_axis_tdata[DATA_W+POS_W-1:DATA_W]),
        .o_wr        (mem_wr),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .i_slot_free (slot_free),
        .o_emit      (emit),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_m_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {2'b00, r_m_res.length, r_m_res.position, r_m_res.value};
    assign o_m_axis_tuser  = r_m_res.status;
    assign o_m_axis_tlast  = r_m_res.last;

endmodule
